@@ rtl/dwcd_pkg.sv @@
// shared types and constants of the depth window contact detector
package dwcd_pkg;

  localparam int RowW   = 11;
  localparam int ColW   = 11;
  localparam int SwW    = 3;
  localparam int DepthW = 16;
  localparam int WordW  = 20;
  localparam int ProdW  = 24;
  localparam int CfgW   = 16;
  localparam int CfgIdxW = 2;
  localparam logic [RowW-1:0] RowLimit = 11'd2047;

  // packed pixel word bit positions
  localparam int BitSdil = 16;
  localparam int BitOdil = 17;
  localparam int BitSmsk = 18;
  localparam int BitOmsk = 19;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEARCH_WIDTH = 2'd0,
    CFG_DEPTH_THRESH = 2'd1,
    CFG_FRAME_ROWS   = 2'd2,
    CFG_FRAME_COLS   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CMP,
    S_CEN,
    S_SCAN,
    S_OUT
  } state_e;

endpackage

@@ rtl/dwcd_pix_if.sv @@
// pixel input channel
interface dwcd_pix_if;
  logic        valid;
  logic        ready;
  logic        pad;
  logic        self_dilated;
  logic        other_dilated;
  logic        self_mask;
  logic        other_mask;
  logic [15:0] depth;

  modport source (output valid, pad, self_dilated, other_dilated, self_mask, other_mask,
                  depth, input ready);
  modport sink (input valid, pad, self_dilated, other_dilated, self_mask, other_mask,
                depth, output ready);
endinterface

@@ rtl/dwcd_res_if.sv @@
// contact result channel
interface dwcd_res_if;
  logic valid;
  logic ready;
  logic contact_self;
  logic contact_other;
  logic frame_end;

  modport source (output valid, contact_self, contact_other, frame_end, input ready);
  modport sink (input valid, contact_self, contact_other, frame_end, output ready);
endinterface

@@ rtl/dwcd_store.sv @@
// pixel line store, one write port and one registered read port
module dwcd_store #(
  parameter int Depth = 9216,
  parameter int AddrW = 14
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [dwcd_pkg::WordW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [dwcd_pkg::WordW-1:0] rdata_o
);
  import dwcd_pkg::*;

  logic [WordW-1:0] mem_q [Depth];
  logic [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/depth_window_contact_detect_core.sv @@
// depth window contact detector: sequencer, counters and window scan over the line store
// sequence: a beat is accepted, multiplied and compared (S_IDLE, S_MUL, S_CMP), which
//   decides whether it emits; an emitting beat then reads the centre data (S_CEN), scans
//   the window (S_SCAN) if needed, and loads the result register (S_OUT)
// input: one beat at a time; S_OUT waits while the result register holds a result not yet taken
// reset: state, counters, configuration and result valid return to their defaults;
//   payload registers and the store hold no reset value
module depth_window_contact_detect_core #(
  parameter int MAX_SEARCH = 4,
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dwcd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dwcd_pkg::CfgW-1:0]     cfg_data_i,
  dwcd_pix_if.sink                      pix_i,
  dwcd_res_if.source                    res_o
);
  import dwcd_pkg::*;

  localparam int Ring  = 2 * MAX_SEARCH + 1;
  localparam int RingW = $clog2(Ring);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int Depth = Ring * MAX_COLS;
  localparam int AddrW = $clog2(Depth);

  state_e state_q, state_d;

  // configuration
  logic [SwW-1:0]    sw_q;
  logic [DepthW-1:0] thr_q;
  logic [RowW-1:0]   frows_q;
  logic [ColW-1:0]   fcols_q;

  // positions, each row counter paired with its ring line
  logic [RowW-1:0]  irow_q, irow_d, orow_q, orow_d;
  logic [ColW-1:0]  icol_q, icol_d, ocol_q, ocol_d;
  logic [RingW-1:0] iring_q, iring_d, oring_q, oring_d;

  // per beat working registers
  logic [RowW-1:0]  lrow_q, lrow_d;
  logic [ColW-1:0]  lcol_q, lcol_d;
  logic [ProdW-1:0] pin_q, pin_d, pout_q, pout_d;
  logic             cin_q, cin_d;
  logic [WordW-1:0] centre_q, centre_d;
  logic [RowW-1:0]  r_q, r_d, r0_q, r0_d, r1_q, r1_d;
  logic [ColW-1:0]  c_q, c_d, c0_q, c0_d, c1_q, c1_d;
  logic [RingW-1:0] rring_q, rring_d, ring0_q, ring0_d;
  logic             issue_q, issue_d, pend_q, pend_d;
  logic             hit_s_q, hit_s_d, hit_o_q, hit_o_d;

  // result register
  logic res_valid_q, res_valid_d, res_cs_q, res_co_q, res_fe_q;
  logic load_res, last;

  // store port
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [WordW-1:0] mem_wdata, mem_rdata;

  // effective frame size and window half size
  logic [RowW-1:0] rows;
  logic [ColW-1:0] cols;
  logic [SwW-1:0]  sw;

  always_comb begin
    if (frows_q == '0) rows = RowW'(1);
    else if (32'(frows_q) > MAX_ROWS) rows = RowW'(MAX_ROWS);
    else rows = frows_q;
    if (fcols_q == '0) cols = ColW'(1);
    else if (32'(fcols_q) > MAX_COLS) cols = ColW'(MAX_COLS);
    else cols = fcols_q;
    if (32'(sw_q) > MAX_SEARCH) sw = SwW'(MAX_SEARCH);
    else sw = sw_q;
  end

  function automatic logic [AddrW-1:0] st_addr(logic [RingW-1:0] ring, logic [ColW-1:0] col);
    st_addr = AddrW'(ring) * AddrW'(MAX_COLS) + AddrW'(CW'(col));
  endfunction

  function automatic logic [RingW-1:0] ring_inc(logic [RingW-1:0] ring);
    ring_inc = (32'(ring) == Ring - 1) ? '0 : ring + RingW'(1);
  endfunction

  dwcd_store #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q    <= SwW'(1);
      thr_q   <= DepthW'(256);
      frows_q <= RowW'(480);
      fcols_q <= ColW'(640);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SEARCH_WIDTH: sw_q    <= cfg_data_i[SwW-1:0];
        CFG_DEPTH_THRESH: thr_q   <= cfg_data_i[DepthW-1:0];
        CFG_FRAME_ROWS:   frows_q <= cfg_data_i[RowW-1:0];
        CFG_FRAME_COLS:   fcols_q <= cfg_data_i[ColW-1:0];
        default: ;
      endcase
    end
  end

  // window scan helpers
  logic [RowW:0]    orow_sw;
  logic [ColW:0]    ocol_sw;
  logic [RowW-1:0]  r0_c;
  logic [ColW-1:0]  c0_c;
  logic [RingW-1:0] delta;
  logic [ProdW-1:0] lin_in, lin_out;
  logic [DepthW-1:0] nd, cd, diff;
  logic             close;
  logic             need_o, need_s;
  logic [WordW-1:0] cen_c;

  always_comb begin
    orow_sw = {1'b0, orow_q} + (RowW+1)'(sw);
    ocol_sw = {1'b0, ocol_q} + (ColW+1)'(sw);
    r0_c    = (orow_q >= RowW'(sw)) ? orow_q - RowW'(sw) : '0;
    c0_c    = (ocol_q >= ColW'(sw)) ? ocol_q - ColW'(sw) : '0;
    delta   = RingW'(orow_q - r0_c);
    lin_in  = pin_q + ProdW'(lcol_q);
    lin_out = pout_q + ProdW'(ocol_q) + ProdW'(sw);
    nd      = mem_rdata[DepthW-1:0];
    cd      = centre_q[DepthW-1:0];
    diff    = (nd > cd) ? nd - cd : cd - nd;
    close   = diff < thr_q;
    cen_c   = cin_q ? mem_rdata : '0;
    need_o  = cen_c[BitSdil] & cen_c[BitOmsk];
    need_s  = cen_c[BitOdil] & cen_c[BitSmsk];
    last    = (orow_q >= rows - RowW'(1)) && (ocol_q >= cols - ColW'(1));
  end

  always_comb begin
    state_d  = state_q;
    irow_d = irow_q;  icol_d = icol_q;  iring_d = iring_q;
    orow_d = orow_q;  ocol_d = ocol_q;  oring_d = oring_q;
    lrow_d = lrow_q;  lcol_d = lcol_q;
    pin_d  = pin_q;   pout_d = pout_q;  cin_d = cin_q;
    centre_d = centre_q;
    r_d = r_q;  r0_d = r0_q;  r1_d = r1_q;
    c_d = c_q;  c0_d = c0_q;  c1_d = c1_q;
    rring_d = rring_q;  ring0_d = ring0_q;
    issue_d = issue_q;  pend_d = 1'b0;
    hit_s_d = hit_s_q;  hit_o_d = hit_o_q;
    load_res = 1'b0;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_waddr = st_addr(iring_q, icol_q);
    mem_raddr = st_addr(rring_q, c_q);
    // pad beats store an empty pixel
    mem_wdata = pix_i.pad ? '0 : {pix_i.other_mask, pix_i.self_mask, pix_i.other_dilated,
                                  pix_i.self_dilated, pix_i.depth};
    pix_i.ready = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (pix_i.valid) begin
          mem_we = (irow_q < rows) && (icol_q < cols);
          lrow_d = irow_q;
          lcol_d = icol_q;
          if ({1'b0, icol_q} + (ColW+1)'(1) >= {1'b0, cols}) begin
            if (irow_q < RowLimit) begin
              icol_d  = '0;
              irow_d  = irow_q + RowW'(1);
              iring_d = ring_inc(iring_q);
            end
          end else begin
            icol_d = icol_q + ColW'(1);
          end
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        pin_d   = ProdW'(lrow_q) * ProdW'(cols);
        pout_d  = ProdW'(orow_sw) * ProdW'(cols);
        state_d = S_CMP;
      end
      S_CMP: begin
        if (lin_in < lin_out) begin
          state_d = S_IDLE;
        end else begin
          // read the centre pixel and set up the clipped window
          mem_re    = 1'b1;
          mem_raddr = st_addr(oring_q, ocol_q);
          cin_d     = (orow_q < rows) && (ocol_q < cols);
          r0_d      = r0_c;
          c0_d      = c0_c;
          r1_d      = (orow_sw < (RowW+1)'(rows - RowW'(1))) ? orow_sw[RowW-1:0]
                                                          : rows - RowW'(1);
          c1_d      = (ocol_sw < (ColW+1)'(cols - ColW'(1))) ? ocol_sw[ColW-1:0]
                                                          : cols - ColW'(1);
          ring0_d   = (oring_q >= delta) ? oring_q - delta
                                         : RingW'(32'(oring_q) + Ring - 32'(delta));
          state_d   = S_CEN;
        end
      end
      S_CEN: begin
        centre_d = cen_c;
        hit_s_d  = 1'b0;
        hit_o_d  = 1'b0;
        if ((need_o || need_s) && (r0_q <= r1_q) && (c0_q <= c1_q)) begin
          r_d     = r0_q;
          c_d     = c0_q;
          rring_d = ring0_q;
          issue_d = 1'b1;
          state_d = S_SCAN;
        end else begin
          state_d = S_OUT;
        end
      end
      S_SCAN: begin
        // one read issued per cycle, data checked the cycle after
        mem_re = issue_q;
        pend_d = issue_q;
        if (pend_q) begin
          hit_o_d = hit_o_q | (centre_q[BitSdil] & centre_q[BitOmsk] &
                               mem_rdata[BitSmsk] & close);
          hit_s_d = hit_s_q | (centre_q[BitOdil] & centre_q[BitSmsk] &
                               mem_rdata[BitOmsk] & close);
        end
        if (issue_q) begin
          if (c_q == c1_q) begin
            if (r_q == r1_q) begin
              issue_d = 1'b0;
            end else begin
              r_d     = r_q + RowW'(1);
              rring_d = ring_inc(rring_q);
              c_d     = c0_q;
            end
          end else begin
            c_d = c_q + ColW'(1);
          end
        end
        if (!issue_q && !pend_q) state_d = S_OUT;
      end
      S_OUT: begin
        if (!res_valid_q || res_o.ready) begin
          load_res = 1'b1;
          if (last) begin
            irow_d = '0;  icol_d = '0;  iring_d = '0;
            orow_d = '0;  ocol_d = '0;  oring_d = '0;
          end else if ({1'b0, ocol_q} + (ColW+1)'(1) >= {1'b0, cols}) begin
            ocol_d = '0;
            if (orow_q < RowLimit) begin
              orow_d  = orow_q + RowW'(1);
              oring_d = ring_inc(oring_q);
            end
          end else begin
            ocol_d = ocol_q + ColW'(1);
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_o.ready) res_valid_d = 1'b0;
    if (load_res) res_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      irow_q      <= '0;
      icol_q      <= '0;
      iring_q     <= '0;
      orow_q      <= '0;
      ocol_q      <= '0;
      oring_q     <= '0;
      issue_q     <= 1'b0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      irow_q      <= irow_d;
      icol_q      <= icol_d;
      iring_q     <= iring_d;
      orow_q      <= orow_d;
      ocol_q      <= ocol_d;
      oring_q     <= oring_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    lrow_q   <= lrow_d;
    lcol_q   <= lcol_d;
    pin_q    <= pin_d;
    pout_q   <= pout_d;
    cin_q    <= cin_d;
    centre_q <= centre_d;
    r_q      <= r_d;
    r0_q     <= r0_d;
    r1_q     <= r1_d;
    c_q      <= c_d;
    c0_q     <= c0_d;
    c1_q     <= c1_d;
    rring_q  <= rring_d;
    ring0_q  <= ring0_d;
    hit_s_q  <= hit_s_d;
    hit_o_q  <= hit_o_d;
    if (load_res) begin
      res_cs_q <= hit_s_q;
      res_co_q <= hit_o_q;
      res_fe_q <= last;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.contact_self  = res_cs_q;
  assign res_o.contact_other = res_co_q;
  assign res_o.frame_end     = res_fe_q;

`ifndef SYNTHESIS
  // the store is never written and read in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(mem_we && mem_re))
    else $error("store write and read collide");

  // a pending scan read only exists while scanning
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q |-> (state_q == S_SCAN))
    else $error("scan read pending outside scan");

  // frame end restarts both positions at the origin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_res && last) |=> (irow_q == '0 && icol_q == '0 && orow_q == '0 && ocol_q == '0))
    else $error("positions not cleared at frame end");
`endif
endmodule
